>>> rtl/core/lvw_pkg.sv
// lvw_pkg: shared types and constants of the 3d line voxel walker
// no dependencies
`timescale 1ns / 1ps

package lvw_pkg;

  localparam int COORD_LIMIT = 64;
  localparam int COORD_W     = 6;
  localparam int GRID_W      = 7;
  localparam int BASE_W      = 32;
  localparam int ID_W        = 33;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;
  localparam int ROW_W       = 13;
  localparam int LIN_W       = 20;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_Z = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ID_BASE = 2'd3;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;
  localparam logic [BASE_W-1:0] BASE_RESET = 32'd0;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] mag;
    logic [2:0]              neg;
    logic [2:0]              major_oh;
    logic [COORD_W-1:0]      mag_major;
  } line_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic [GRID_W-1:0] grid_z;
    logic [BASE_W-1:0] id_base;
  } cfg_t;

  function automatic coord_t clamp_coord(input coord_t v);
    if (COORD_W'(COORD_LIMIT - 1) < v) clamp_coord = COORD_W'(COORD_LIMIT - 1);
    else clamp_coord = v;
  endfunction

endpackage

>>> rtl/core/line_voxel_walker_3d.sv
// line_voxel_walker_3d: top level, configuration registers, front, queue and back
// depends on lvw_pkg, lvw_front, lvw_queue, lvw_back
`timescale 1ns / 1ps

// Each accepted line (start and end voxel) produces max(|dx|,|dy|,|dz|)+1 result
// items, one per cycle from the step sequencer in the back end while the output is
// not stalled; the next queued line starts in the cycle after the final step of the
// current one. Results leave through the voxel id pipeline (two multiply stages and
// the base add). A two-entry queue lets input items be taken while a line is being
// walked. Grid and base registers may only be written while no line is in flight.

module line_voxel_walker_3d (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lvw_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [lvw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, zero fill
  input  logic [lvw_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // voxel_id, zero fill
  output logic [lvw_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast,
  // in_grid
  output logic                                 out_tuser
);

  lvw_pkg::cfg_t  cfg_r;
  lvw_pkg::line_t wr_item, rd_item;
  logic           q_full, q_push, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_x  <= lvw_pkg::GRID_RESET;
      cfg_r.grid_y  <= lvw_pkg::GRID_RESET;
      cfg_r.grid_z  <= lvw_pkg::GRID_RESET;
      cfg_r.id_base <= lvw_pkg::BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lvw_pkg::REG_GRID_X:  cfg_r.grid_x  <= cfg_wdata[lvw_pkg::GRID_W-1:0];
        lvw_pkg::REG_GRID_Y:  cfg_r.grid_y  <= cfg_wdata[lvw_pkg::GRID_W-1:0];
        lvw_pkg::REG_GRID_Z:  cfg_r.grid_z  <= cfg_wdata[lvw_pkg::GRID_W-1:0];
        lvw_pkg::REG_ID_BASE: cfg_r.id_base <= cfg_wdata[lvw_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  lvw_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (wr_item)
  );

  lvw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_item  (wr_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (rd_item)
  );

  lvw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (rd_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/core/lvw_front.sv
// lvw_front: accepts line items, takes the per-axis deltas and picks the major axis
// depends on lvw_pkg
`timescale 1ns / 1ps

module lvw_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lvw_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          q_full,
  output logic                          q_push,
  output lvw_pkg::line_t                q_item
);

  lvw_pkg::coord_t s [3];
  lvw_pkg::coord_t e [3];
  logic [1:0]      maj;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s[a] = lvw_pkg::clamp_coord(in_tdata[a*lvw_pkg::COORD_W +: lvw_pkg::COORD_W]);
      e[a] = lvw_pkg::clamp_coord(in_tdata[(a+3)*lvw_pkg::COORD_W +: lvw_pkg::COORD_W]);
      q_item.pos[a] = s[a];
      q_item.neg[a] = e[a] < s[a];
      q_item.mag[a] = (e[a] < s[a]) ? (s[a] - e[a]) : (e[a] - s[a]);
    end
    maj = 2'(lvw_pkg::AXIS_X);
    if (q_item.mag[lvw_pkg::AXIS_Y] > q_item.mag[lvw_pkg::AXIS_X])
      maj = 2'(lvw_pkg::AXIS_Y);
    if (q_item.mag[lvw_pkg::AXIS_Z] > q_item.mag[maj])
      maj = 2'(lvw_pkg::AXIS_Z);
    q_item.major_oh = 3'b001 << maj;
    q_item.mag_major = q_item.mag[maj];
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

>>> rtl/core/lvw_queue.sv
// lvw_queue: short queue of classified line items between front and back
// depends on lvw_pkg
`timescale 1ns / 1ps

module lvw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lvw_pkg::line_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output lvw_pkg::line_t rd_item
);

  lvw_pkg::line_t                 mem [lvw_pkg::Q_DEPTH];
  logic [lvw_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lvw_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lvw_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full     = cnt_r == lvw_pkg::Q_CNT_W'(lvw_pkg::Q_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + lvw_pkg::Q_CNT_W'(push) - lvw_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> rd_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("queue pushed while full");
  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

>>> rtl/core/lvw_back.sv
// lvw_back: steps a voxel per unstalled cycle, forms voxel ids in a short pipeline
// depends on lvw_pkg
`timescale 1ns / 1ps

module lvw_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lvw_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  input  lvw_pkg::line_t                 q_item,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lvw_pkg::OUT_DATA_W-1:0] out_tdata,   // voxel_id, zero fill
  output logic                           out_tlast,
  output logic                           out_tuser    // in_grid
);

  // walker state
  logic                                   active_r, active_nxt;
  logic [2:0][lvw_pkg::COORD_W-1:0]       pos_r, pos_nxt;
  logic [2:0][lvw_pkg::COORD_W-1:0]       mag_r, mag_nxt;
  logic [2:0][lvw_pkg::COORD_W-1:0]       rem_r, rem_nxt;
  logic [2:0]                             neg_r, neg_nxt;
  logic [2:0]                             major_r, major_nxt;
  logic [lvw_pkg::COORD_W-1:0]            magmaj_r, magmaj_nxt;
  logic [lvw_pkg::COORD_W-1:0]            cnt_r, cnt_nxt;
  logic [lvw_pkg::COORD_W:0]              sum [3];
  logic                                   en, last, step;

  // id pipeline
  logic                                   s1_valid_r, s2_valid_r, out_valid_r;
  logic [lvw_pkg::ROW_W-1:0]              s1_row_r;
  logic [lvw_pkg::COORD_W-1:0]            s1_x_r;
  logic                                   s1_grid_r, s1_last_r;
  logic [lvw_pkg::LIN_W-1:0]              s2_lin_r;
  logic                                   s2_grid_r, s2_last_r;
  logic [lvw_pkg::ID_W-1:0]               out_id_r;
  logic                                   out_grid_r, out_last_r;

  assign en    = !out_valid_r || out_tready;
  assign last  = cnt_r == '0;
  assign step  = active_r && en;
  assign q_pop = q_valid && (!active_r || (step && last));

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    mag_nxt    = mag_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    major_nxt  = major_r;
    magmaj_nxt = magmaj_r;
    cnt_nxt    = cnt_r;
    for (int a = 0; a < 3; a++) begin
      sum[a] = {1'b0, rem_r[a]} + {1'b0, mag_r[a]};
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      pos_nxt    = q_item.pos;
      mag_nxt    = q_item.mag;
      rem_nxt    = '0;
      neg_nxt    = q_item.neg;
      major_nxt  = q_item.major_oh;
      magmaj_nxt = q_item.mag_major;
      cnt_nxt    = q_item.mag_major;
    end else if (step && last) begin
      active_nxt = 1'b0;
    end else if (step) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (major_r[a]) begin
          pos_nxt[a] = neg_r[a] ? pos_r[a] - 1'b1 : pos_r[a] + 1'b1;
        end else if (sum[a] >= {1'b0, magmaj_r}) begin
          rem_nxt[a] = lvw_pkg::COORD_W'(sum[a] - {1'b0, magmaj_r});
          pos_nxt[a] = neg_r[a] ? pos_r[a] - 1'b1 : pos_r[a] + 1'b1;
        end else begin
          rem_nxt[a] = sum[a][lvw_pkg::COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    pos_r    <= pos_nxt;
    mag_r    <= mag_nxt;
    rem_r    <= rem_nxt;
    neg_r    <= neg_nxt;
    major_r  <= major_nxt;
    magmaj_r <= magmaj_nxt;
    cnt_r    <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= active_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_row_r   <= lvw_pkg::ROW_W'(cfg.grid_y) * lvw_pkg::ROW_W'(pos_r[lvw_pkg::AXIS_Z])
                    + lvw_pkg::ROW_W'(pos_r[lvw_pkg::AXIS_Y]);
      s1_x_r     <= pos_r[lvw_pkg::AXIS_X];
      s1_grid_r  <= ({1'b0, pos_r[lvw_pkg::AXIS_X]} < cfg.grid_x)
                 && ({1'b0, pos_r[lvw_pkg::AXIS_Y]} < cfg.grid_y)
                 && ({1'b0, pos_r[lvw_pkg::AXIS_Z]} < cfg.grid_z);
      s1_last_r  <= last;
      s2_lin_r   <= lvw_pkg::LIN_W'(cfg.grid_x) * lvw_pkg::LIN_W'(s1_row_r)
                    + lvw_pkg::LIN_W'(s1_x_r);
      s2_grid_r  <= s1_grid_r;
      s2_last_r  <= s1_last_r;
      out_id_r   <= lvw_pkg::ID_W'(cfg.id_base) + lvw_pkg::ID_W'(s2_lin_r);
      out_grid_r <= s2_grid_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lvw_pkg::OUT_DATA_W'(out_id_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_grid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    active_r && magmaj_r != '0 |->
      rem_r[0] < magmaj_r && rem_r[1] < magmaj_r && rem_r[2] < magmaj_r)
    else $error("minor remainder reached the major delta");
  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> $onehot(major_r) && cnt_r <= magmaj_r)
    else $error("walker step count or major axis corrupt");
  assert property (@(posedge clk) disable iff (!rst_n)
    !en && s2_valid_r |=> s2_valid_r)
    else $error("pipeline dropped an item under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    step && !last |=> active_r)
    else $error("walker stopped before the final step");

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for line_voxel_walker_3d, with a voxel step predictor
// in a small scoreboard class and plain tasks for the stream and register ports
// depends on lvw_pkg and line_voxel_walker_3d
`timescale 1ns / 1ps

module testbench;
  import lvw_pkg::*;

  localparam int NUM_PHASES       = 8;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int SETTLE_CYCLES    = 10;
  localparam int IDLE_LIMIT       = 4000;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            in_grid;
    logic            last;
  } voxel_step_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_BURSTY} rx_mode_e;

  class voxel_scoreboard;
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic [GRID_W-1:0] grid_z;
    logic [BASE_W-1:0] base;
    voxel_step_t       walk_q[$];
    int                errors;
    int                lines;
    int                steps_checked;
    int                outside;

    function new();
      grid_x = GRID_RESET;
      grid_y = GRID_RESET;
      grid_z = GRID_RESET;
      base   = BASE_RESET;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_GRID_X:  grid_x = v[GRID_W-1:0];
        REG_GRID_Y:  grid_y = v[GRID_W-1:0];
        REG_GRID_Z:  grid_z = v[GRID_W-1:0];
        REG_ID_BASE: base = v[BASE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return walk_q.size();
    endfunction

    // predicted voxel steps of one accepted line
    function void note_line(logic [IN_DATA_W-1:0] d);
      int          pos[3];
      int          mag[3];
      int          rem[3];
      bit          neg[3];
      int          major;
      int          m1;
      int          m2;
      int          ax;
      int          span;
      int          st;
      int          en;
      logic [63:0] lin;
      voxel_step_t s;
      for (int a = 0; a < 3; a++) begin
        st = d[a*COORD_W +: COORD_W];
        en = d[(a+3)*COORD_W +: COORD_W];
        pos[a] = st;
        neg[a] = en < st;
        mag[a] = neg[a] ? st - en : en - st;
        rem[a] = 0;
      end
      major = AXIS_X;
      if (mag[AXIS_Y] > mag[major]) major = AXIS_Y;
      if (mag[AXIS_Z] > mag[major]) major = AXIS_Z;
      m1 = (major + 1) % 3;
      m2 = (major + 2) % 3;
      span = mag[major] + 1;
      lines++;
      for (int n = 0; n < span; n++) begin
        lin = (64'(pos[AXIS_Z]) * grid_y + 64'(pos[AXIS_Y])) * grid_x + 64'(pos[AXIS_X]);
        s.id = ID_W'(64'(base) + lin);
        s.in_grid = (pos[AXIS_X] < grid_x) && (pos[AXIS_Y] < grid_y) &&
                    (pos[AXIS_Z] < grid_z);
        s.last = (n == span - 1);
        if (!s.in_grid) outside++;
        walk_q.push_back(s);
        if (n == span - 1) break;
        pos[major] = neg[major] ? pos[major] - 1 : pos[major] + 1;
        for (int k = 0; k < 2; k++) begin
          ax = k ? m2 : m1;
          rem[ax] += mag[ax];
          if (rem[ax] >= mag[major]) begin
            rem[ax] -= mag[major];
            pos[ax] = neg[ax] ? pos[ax] - 1 : pos[ax] + 1;
          end
        end
      end
    endfunction

    function void check_step(logic [ID_W-1:0] id, logic in_grid, logic last);
      voxel_step_t want;
      if (walk_q.size() == 0) begin
        $error("unexpected voxel item: voxel_id %0h in_grid %0b last_step %0b",
               id, in_grid, last);
        errors++;
        return;
      end
      want = walk_q.pop_front();
      steps_checked++;
      if (id !== want.id) begin
        $error("voxel_id mismatch: expected %0h, got %0h", want.id, id);
        errors++;
      end
      if (in_grid !== want.in_grid) begin
        $error("in_grid mismatch: expected %0b, got %0b", want.in_grid, in_grid);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_step mismatch: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tlast;
  logic                    out_tuser;

  voxel_scoreboard sb = new();
  rx_mode_e        rx_mode = RX_BURSTY;
  int              rx_hold;
  int              idle_cycles;
  int              burst_left;
  bit              tx_gaps;

  line_voxel_walker_3d i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_tready <= !out_tready;
          rx_hold <= out_tready ? $urandom_range(0, 7) : $urandom_range(0, 12);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) sb.note_line(in_tdata);
      if (out_tvalid && out_tready) sb.check_step(out_tdata[ID_W-1:0], out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("stalled for %0d cycles with nothing accepted", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic write_grid(input int gx, input int gy, input int gz, input logic [31:0] b);
    reg_write(REG_GRID_X, CFG_DATA_W'(gx));
    reg_write(REG_GRID_Y, CFG_DATA_W'(gy));
    reg_write(REG_GRID_Z, CFG_DATA_W'(gz));
    reg_write(REG_ID_BASE, b);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_line(input int sx, input int sy, input int sz,
                           input int ex, input int ey, input int ez);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (tx_gaps) gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                   : $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, coord_t'(ez), coord_t'(ey), coord_t'(ex),
                 coord_t'(sz), coord_t'(sy), coord_t'(sx)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  function automatic int near(int c);
    int v;
    v = c + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > COORD_LIMIT - 1) v = COORD_LIMIT - 1;
    return v;
  endfunction

  // mix of long, short, one-long-axis and zero-length lines
  task automatic send_random_line();
    int sx, sy, sz, ex, ey, ez;
    int shape;
    sx = $urandom_range(0, 63);
    sy = $urandom_range(0, 63);
    sz = $urandom_range(0, 63);
    shape = $urandom_range(0, 99);
    if (shape < 45) begin
      ex = $urandom_range(0, 63);
      ey = $urandom_range(0, 63);
      ez = $urandom_range(0, 63);
    end else if (shape < 80) begin
      ex = near(sx);
      ey = near(sy);
      ez = near(sz);
    end else if (shape < 95) begin
      ex = near(sx);
      ey = near(sy);
      ez = near(sz);
      case ($urandom_range(0, 2))
        AXIS_X:  ex = $urandom_range(0, 63);
        AXIS_Y:  ey = $urandom_range(0, 63);
        default: ez = $urandom_range(0, 63);
      endcase
    end else begin
      ex = sx;
      ey = sy;
      ez = sz;
    end
    send_line(sx, sy, sz, ex, ey, ez);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    tx_gaps = 1'b1;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid, directed lines
    send_line(0, 0, 0, 0, 0, 0);
    send_line(63, 63, 63, 63, 63, 63);
    send_line(0, 0, 0, 63, 63, 63);
    send_line(63, 63, 63, 0, 0, 0);
    send_line(0, 0, 0, 63, 0, 0);
    send_line(0, 0, 0, 0, 63, 0);
    send_line(0, 0, 0, 0, 0, 63);
    send_line(63, 0, 0, 0, 5, 9);
    send_line(10, 63, 20, 12, 0, 30);
    send_line(5, 5, 63, 0, 40, 0);
    send_line(0, 0, 0, 20, 20, 5);
    send_line(30, 0, 0, 31, 17, 17);
    send_line(0, 10, 0, 9, 12, 9);
    send_line(1, 2, 3, 4, 5, 6);
    send_line(63, 0, 63, 0, 63, 0);
    send_line(42, 21, 7, 21, 42, 63);
    send_line(42, 21, 42, 21, 42, 21);
    drain();

    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: write_grid(64, 64, 64, 32'hFFFF_FFFF);
        2: write_grid(1, 1, 1, 32'h0);
        3: write_grid(0, 127, 33, $urandom);
        4: write_grid(127, 127, 127, $urandom);
        default: write_grid($urandom_range(1, 64), $urandom_range(1, 64),
                            $urandom_range(1, 64), $urandom);
      endcase
      rx_mode = rx_mode_e'(ph % 3);
      tx_gaps = (ph % 4 != 1);
      repeat (RANDOM_PER_PHASE) send_random_line();
      drain();
    end

    $display("walked %0d lines over %0d grid settings, %0d voxel items checked",
             sb.lines, NUM_PHASES, sb.steps_checked);
    $display("%0d of the voxels fell outside the grid, %0d mismatches",
             sb.outside, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
